[hdl/skid_steer_pwm_ramp_controller_assert.svh]
// Assertion macros shared by the checker of the skid-steer ramp controller.
`ifndef SKID_STEER_PWM_RAMP_CONTROLLER_ASSERT_SVH
`define SKID_STEER_PWM_RAMP_CONTROLLER_ASSERT_SVH

// Property that must hold at every clock edge outside of reset.
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define SSP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/ssp_pkg.sv]
// Shared constants and codes of the skid-steer PWM ramp controller.
package ssp_pkg;

  localparam int unsigned MOTORS      = 4;
  localparam int unsigned PPR_DEFAULT = 90;
  localparam int unsigned RPM_SCALE   = 60000;
  localparam int unsigned PWM_W       = 12;
  localparam int unsigned DRIVE_W     = 13;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned VEL_W       = 16;
  localparam int unsigned ELAPSED_W   = 16;
  localparam int unsigned PULSE_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned ERR_W       = 13;
  localparam int unsigned DIV_W       = 48;
  localparam int unsigned RPM_STEPS   = 16;
  localparam int unsigned RAMP_STEPS  = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_TRACK = 3'd0,
    CFG_VEL_GAIN   = 3'd1,
    CFG_PWM_MAX    = 3'd2,
    CFG_RAMP_STEP  = 3'd3,
    CFG_TIMEOUT    = 3'd4
  } cfg_idx_e;

endpackage

[hdl/ssp_if.sv]
// Channel interfaces: configuration writes, input items and result items.
interface ssp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface ssp_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] linear_vel;
  logic signed [15:0] angular_vel;
  logic [15:0]        elapsed_ms;
  logic signed [31:0] pulses_fl;
  logic signed [31:0] pulses_fr;
  logic signed [31:0] pulses_rl;
  logic signed [31:0] pulses_rr;
  modport source (output valid, cmd, linear_vel, angular_vel, elapsed_ms,
                  pulses_fl, pulses_fr, pulses_rl, pulses_rr, input ready);
  modport sink (input valid, cmd, linear_vel, angular_vel, elapsed_ms,
                pulses_fl, pulses_fr, pulses_rl, pulses_rr, output ready);
endinterface

interface ssp_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] drive_fl;
  logic signed [12:0] drive_fr;
  logic signed [12:0] drive_rl;
  logic signed [12:0] drive_rr;
  logic signed [15:0] speed_fl;
  logic signed [15:0] speed_fr;
  logic signed [15:0] speed_rl;
  logic signed [15:0] speed_rr;
  modport source (output valid, drive_fl, drive_fr, drive_rl, drive_rr,
                  speed_fl, speed_fr, speed_rl, speed_rr, input ready);
  modport sink (input valid, drive_fl, drive_fr, drive_rl, drive_rr,
                speed_fl, speed_fr, speed_rl, speed_rr, output ready);
endinterface

[hdl/skid_steer_pwm_ramp_controller.sv]
// Top level of the four-motor skid-steer PWM ramp controller.
// Channels: cfg_i takes register writes (always ready), in_i takes items,
// out_o delivers one result per control tick and none per velocity command.
// A velocity command mixes linear and angular velocity into left and right
// PWM targets, one side after the other, and gives no result.
// A control tick measures RPM per motor, ramps the PWMs and emits a result
// after these steps: an error scan, then per motor a load, the RPM divide
// (skipped for zero elapsed time), the RPM step, the ramp divide (skipped
// when all errors are zero) and the update, then a finish. All divisions run
// one quotient bit per cycle on a single shared restoring divider.
// in_i.ready is high only while the sequencer is idle, one item at a time.
// The result sits in an output register; the next item is taken while it
// waits. If out_o stalls when a tick finishes, the sequencer holds there.
// Reset loads the default registers, zeroes PWMs, targets, encoder history
// and the command timer, and sets all directions to forward.
module skid_steer_pwm_ramp_controller #(
  parameter int unsigned PULSES_PER_REV = ssp_pkg::PPR_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssp_cfg_if.sink   cfg_i,
  ssp_in_if.sink    in_i,
  ssp_out_if.source out_o
);
  import ssp_pkg::*;

  localparam int unsigned PPR_W = $clog2(PULSES_PER_REV + 1);
  localparam int unsigned DEN_W = ELAPSED_W + PPR_W;
  localparam int unsigned MI_W  = $clog2(MOTORS);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_TURN = 9'b000000010,
    ST_MIX  = 9'b000000100,
    ST_ERR  = 9'b000001000,
    ST_LOAD = 9'b000010000,
    ST_DIV  = 9'b000100000,
    ST_RPM  = 9'b001000000,
    ST_SDIV = 9'b010000000,
    ST_PWM  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] half_track_q, vel_gain_q, timeout_q;
  logic [11:0] pwm_max_q;
  logic [7:0]  ramp_step_q;

  // Motor state.
  logic [PWM_W-1:0]   present_q [MOTORS];
  logic [PWM_W-1:0]   goal_q    [MOTORS];
  logic [MOTORS-1:0]  dir_q, gdir_q;
  logic [PULSE_W-1:0] prior_q   [MOTORS];
  logic [31:0]        since_q;

  // Latched item and working registers.
  logic signed [VEL_W-1:0] v_q, w_q;
  logic [ELAPSED_W-1:0]    elapsed_q;
  logic [PULSE_W-1:0]      pulses_q [MOTORS];
  logic signed [32:0]      turn_q;
  logic                    side_q;
  logic [ERR_W-1:0]        err_q [MOTORS];
  logic [ERR_W-1:0]        maxerr_q;
  logic [DEN_W-1:0]        den_q;
  logic [MI_W-1:0]         mi_q;
  logic [DIV_W-1:0]        rem_q, dsh_q;
  logic [RPM_STEPS-1:0]    quo_q;
  logic [3:0]              cnt_q;
  logic                    neg_q;
  logic [SPEED_W-1:0]      speed_q [MOTORS];
  logic                    done_q;

  // Output register.
  logic                      out_valid_q;
  logic [DRIVE_W-1:0]        out_drive_q [MOTORS];
  logic [SPEED_W-1:0]        out_speed_q [MOTORS];

  logic in_xfer, out_free;
  assign in_i.ready  = (state_q == ST_IDLE) && !done_q;
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // Wheel mix and target for the side in work.
  logic signed [33:0] mix;
  logic signed [50:0] prod;
  logic [50:0]        pabs;
  logic [22:0]        mag;
  logic [PWM_W-1:0]   target;
  always_comb begin
    mix = {{6{v_q[15]}}, v_q, 12'b0} + (side_q ? {turn_q[32], turn_q}
                                              : -{turn_q[32], turn_q});
    prod   = mix * $signed({1'b0, vel_gain_q});
    pabs   = prod[50] ? 51'(-prod) : prod;
    mag    = pabs[50:28];
    target = (mag > {11'b0, pwm_max_q}) ? pwm_max_q : mag[PWM_W-1:0];
  end

  // Ramp error per motor from the state before the tick.
  logic [ERR_W-1:0] err_c [MOTORS];
  logic [ERR_W-1:0] max01, max23, maxerr_c;
  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      if (dir_q[i] == gdir_q[i]) begin
        err_c[i] = (goal_q[i] > present_q[i]) ? ERR_W'(goal_q[i] - present_q[i])
                                              : ERR_W'(present_q[i] - goal_q[i]);
      end else begin
        err_c[i] = ERR_W'(goal_q[i]) + ERR_W'(present_q[i]);
      end
    end
    max01    = (err_c[0] > err_c[1]) ? err_c[0] : err_c[1];
    max23    = (err_c[2] > err_c[3]) ? err_c[2] : err_c[3];
    maxerr_c = (max01 > max23) ? max01 : max23;
  end

  // Encoder difference scaled to counts times ms per minute.
  logic signed [31:0] diff;
  logic signed [48:0] num;
  logic [48:0]        num_abs;
  always_comb begin
    diff    = $signed(pulses_q[mi_q] - prior_q[mi_q]);
    num     = diff * $signed(17'(RPM_SCALE));
    num_abs = num[48] ? 49'(-num) : num;
  end

  // Shared restoring divider step.
  logic                 div_ge;
  logic [DIV_W-1:0]     rem_n;
  always_comb begin
    div_ge = rem_q >= dsh_q;
    rem_n  = div_ge ? rem_q - dsh_q : rem_q;
  end

  // RPM from the quotient, saturated to 16 bits.
  logic [SPEED_W-1:0] rpm_c;
  logic               rpm_zero;
  always_comb begin
    rpm_zero = (quo_q == '0);
    if (quo_q[RPM_STEPS-1]) begin
      rpm_c = neg_q ? 16'h8000 : 16'h7FFF;
    end else begin
      rpm_c = neg_q ? 16'(-{1'b0, quo_q[14:0]}) : {1'b0, quo_q[14:0]};
    end
  end

  // PWM ramp for the motor in work.
  logic [7:0]       step;
  logic [PWM_W-1:0] pres, goal, pwm_n;
  logic [PWM_W:0]   sum;
  always_comb begin
    step  = quo_q[7:0];
    pres  = present_q[mi_q];
    goal  = goal_q[mi_q];
    sum   = {1'b0, pres} + {5'b0, step};
    pwm_n = pres;
    if (dir_q[mi_q] != gdir_q[mi_q]) begin
      pwm_n = (pres > {4'b0, step}) ? pres - {4'b0, step} : '0;
    end else if (pres < goal) begin
      pwm_n = (sum > {1'b0, goal}) ? goal : sum[PWM_W-1:0];
    end else if (pres > goal) begin
      pwm_n = ((pres - goal) > {4'b0, step}) ? pres - {4'b0, step} : goal;
    end
  end

  // Command timer, saturating.
  logic [32:0] since_sum;
  logic [31:0] since_n;
  always_comb begin
    since_sum = {1'b0, since_q} + {17'b0, elapsed_q};
    since_n   = since_sum[32] ? '1 : since_sum[31:0];
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = in_i.cmd ? ST_ERR : ST_TURN;
      ST_TURN: state_d = ST_MIX;
      ST_MIX:  if (side_q) state_d = ST_IDLE;
      ST_ERR:  state_d = ST_LOAD;
      ST_LOAD: state_d = (elapsed_q == '0) ? ST_RPM : ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_RPM;
      ST_RPM:  state_d = (maxerr_q == '0) ? ST_PWM : ST_SDIV;
      ST_SDIV: if (cnt_q == '0) state_d = ST_PWM;
      ST_PWM:  state_d = (mi_q == MI_W'(MOTORS - 1)) ? ST_IDLE : ST_LOAD;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and motor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      half_track_q <= 16'd2048;
      vel_gain_q   <= 16'd65280;
      pwm_max_q    <= 12'd255;
      ramp_step_q  <= 8'd3;
      timeout_q    <= 16'd5000;
      dir_q        <= '1;
      gdir_q       <= '1;
      since_q      <= '0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
        present_q[i] <= '0;
        goal_q[i]    <= '0;
        prior_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_HALF_TRACK: half_track_q <= cfg_i.data;
          CFG_VEL_GAIN:   vel_gain_q   <= cfg_i.data;
          CFG_PWM_MAX:    pwm_max_q    <= cfg_i.data[11:0];
          CFG_RAMP_STEP:  ramp_step_q  <= cfg_i.data[7:0];
          CFG_TIMEOUT:    timeout_q    <= cfg_i.data;
          default: ;
        endcase
      end
      if (out_o.ready && !(done_q && out_free)) out_valid_q <= 1'b0;
      if (state_q == ST_MIX) begin
        for (int i = 0; i < MOTORS; i++) begin
          if ((i % 2) == int'(side_q)) begin
            goal_q[i] <= target;
            gdir_q[i] <= !prod[50];
          end
        end
        if (side_q) since_q <= '0;
      end
      if ((state_q == ST_LOAD) && (elapsed_q != '0)) prior_q[mi_q] <= pulses_q[mi_q];
      if ((state_q == ST_RPM) && (dir_q[mi_q] != gdir_q[mi_q]) && rpm_zero) begin
        dir_q[mi_q] <= gdir_q[mi_q];
      end
      if (state_q == ST_PWM) begin
        present_q[mi_q] <= pwm_n;
        if (mi_q == MI_W'(MOTORS - 1)) done_q <= 1'b1;
      end
      // Finish the tick: timer, timeout and the result register.
      if (done_q && out_free) begin
        done_q      <= 1'b0;
        out_valid_q <= 1'b1;
        since_q     <= since_n;
        if (since_n > {16'b0, timeout_q}) begin
          gdir_q <= '1;
          for (int i = 0; i < MOTORS; i++) goal_q[i] <= '0;
        end
      end
    end
  end

  // Working registers of the sequencer and the divider.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      v_q         <= in_i.linear_vel;
      w_q         <= in_i.angular_vel;
      elapsed_q   <= in_i.elapsed_ms;
      pulses_q[0] <= in_i.pulses_fl;
      pulses_q[1] <= in_i.pulses_fr;
      pulses_q[2] <= in_i.pulses_rl;
      pulses_q[3] <= in_i.pulses_rr;
      side_q      <= 1'b0;
      mi_q        <= '0;
    end
    unique case (state_q)
      ST_TURN: turn_q <= w_q * $signed({1'b0, half_track_q});
      ST_MIX:  side_q <= 1'b1;
      ST_ERR: begin
        for (int i = 0; i < MOTORS; i++) err_q[i] <= err_c[i];
        maxerr_q <= maxerr_c;
        den_q    <= elapsed_q * PPR_W'(PULSES_PER_REV);
      end
      ST_LOAD: begin
        quo_q <= '0;
        neg_q <= num[48];
        rem_q <= num_abs[DIV_W-1:0];
        dsh_q <= DIV_W'(den_q) << (RPM_STEPS - 1);
        cnt_q <= 4'(RPM_STEPS - 1);
      end
      ST_DIV, ST_SDIV: begin
        rem_q <= rem_n;
        dsh_q <= dsh_q >> 1;
        quo_q <= {quo_q[RPM_STEPS-2:0], div_ge};
        cnt_q <= cnt_q - 4'd1;
      end
      ST_RPM: begin
        speed_q[mi_q] <= rpm_c;
        quo_q <= '0;
        rem_q <= DIV_W'(ramp_step_q * err_q[mi_q]);
        dsh_q <= DIV_W'(maxerr_q) << (RAMP_STEPS - 1);
        cnt_q <= 4'(RAMP_STEPS - 1);
      end
      ST_PWM:  mi_q <= mi_q + MI_W'(1);
      default: ;
    endcase
    if (done_q && out_free) begin
      for (int i = 0; i < MOTORS; i++) begin
        out_drive_q[i] <= dir_q[i] ? {1'b0, present_q[i]} : DRIVE_W'(-{1'b0, present_q[i]});
        out_speed_q[i] <= speed_q[i];
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.drive_fl = out_drive_q[0];
  assign out_o.drive_fr = out_drive_q[1];
  assign out_o.drive_rl = out_drive_q[2];
  assign out_o.drive_rr = out_drive_q[3];
  assign out_o.speed_fl = out_speed_q[0];
  assign out_o.speed_fr = out_speed_q[1];
  assign out_o.speed_rl = out_speed_q[2];
  assign out_o.speed_rr = out_speed_q[3];

endmodule

[hdl/ssp_checker.sv]
// Port-level checker of the skid-steer ramp controller and its bind.
`include "skid_steer_pwm_ramp_controller_assert.svh"

module ssp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [12:0] drive_fl_i,
  input logic [15:0] speed_fl_i,
  input logic        cfg_ready_i
);

  // A waiting result keeps its front-left drive and speed until it is taken.
  `SSP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_fl_i) && $stable(speed_fl_i), "result changed while stalled")

  // After an input transfer, input ready is low in the cycle after it.
  `SSP_ASSERT(a_busy_after_in, in_valid_i && in_ready_i |=> !in_ready_i, "input ready right after a transfer")

  // A new result only appears at the end of work on an item.
  `SSP_ASSERT(a_result_from_work, $rose(out_valid_i) |-> $past(!in_ready_i), "result without work")

  // Register writes are never refused.
  `SSP_NEVER(a_cfg_ready, !cfg_ready_i, "configuration port not ready")

endmodule

bind skid_steer_pwm_ramp_controller ssp_checker u_ssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_fl_i  (out_o.drive_fl),
  .speed_fl_i  (out_o.speed_fl),
  .cfg_ready_i (cfg_i.ready)
);

[verif/skid_steer_pwm_ramp_controller_tb.sv]
// Self-checking testbench of the skid-steer PWM ramp controller.
`timescale 1ns / 1ps

module skid_steer_pwm_ramp_controller_tb;
  import ssp_pkg::*;

  localparam int unsigned ENC_PER_REV = 90;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [12:0] drive[4];
    logic signed [15:0] speed[4];
  } motor_report_t;

  typedef struct {
    bit                 tick;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [15:0]        elapsed;
    logic [31:0]        pulses[4];
    bit                 typed;
    motor_report_t      typed_report;
  } drive_item_t;

  logic clk;
  logic rst_n;

  ssp_cfg_if cfg_ch();
  ssp_in_if  in_ch();
  ssp_out_if out_ch();

  skid_steer_pwm_ramp_controller dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Register copy of the controller, kept by the predictor.
  int unsigned track_half, gain, pwm_cap, slew, timeout_ms;
  // Motor state of the predictor.
  int unsigned pwm_now[4], pwm_goal[4], enc_last[4];
  bit          fwd_now[4], fwd_goal[4];
  int unsigned quiet_ms;

  motor_report_t report_queue[$];
  drive_item_t   directed_rows[$];
  logic [31:0]   enc_pos[4];

  int unsigned errors, mismatches, cycles, ticks_sent, cmds_sent, phases_run;
  bit          calm;

  // Clock.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycles,
               report_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Gap length: mostly none or short, a few long; none while calm.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void reset_model();
    track_half = 2048;
    gain = 65280;
    pwm_cap = 255;
    slew = 3;
    timeout_ms = 5000;
    for (int i = 0; i < 4; i++) begin
      pwm_now[i] = 0;
      pwm_goal[i] = 0;
      fwd_now[i] = 1'b1;
      fwd_goal[i] = 1'b1;
      enc_last[i] = 0;
    end
    quiet_ms = 0;
  endfunction

  // Scale one side's mixed demand into a target magnitude and direction.
  function automatic void mix_side(longint mix, int first);
    longint p, mag;
    p = mix * longint'(gain);
    mag = (p < 0 ? -p : p) >>> 28;
    if (mag > longint'(pwm_cap)) mag = pwm_cap;
    for (int i = first; i < 4; i += 2) begin
      pwm_goal[i] = int'(mag);
      fwd_goal[i] = (p >= 0);
    end
  endfunction

  // Predict the effect of one accepted item; returns 1 when it yields a report.
  function automatic bit predict_motion(drive_item_t it, output motor_report_t rep);
    longint turn, rpm, diff, den, s;
    int unsigned err[4];
    int unsigned max_err, step;
    max_err = 0;
    if (!it.tick) begin
      turn = longint'(it.ang) * longint'(track_half);
      mix_side(longint'(it.lin) * 4096 - turn, 0);
      mix_side(longint'(it.lin) * 4096 + turn, 1);
      quiet_ms = 0;
      return 1'b0;
    end
    // Errors across all motors set the common ramp ratio.
    for (int i = 0; i < 4; i++) begin
      if (fwd_now[i] == fwd_goal[i])
        err[i] = pwm_goal[i] > pwm_now[i] ? pwm_goal[i] - pwm_now[i] : pwm_now[i] - pwm_goal[i];
      else
        err[i] = pwm_goal[i] + pwm_now[i];
      if (err[i] > max_err) max_err = err[i];
    end
    for (int i = 0; i < 4; i++) begin
      rpm = 0;
      if (it.elapsed != 0) begin
        diff = longint'($signed(it.pulses[i] - enc_last[i]));
        den = longint'(it.elapsed) * ENC_PER_REV;
        enc_last[i] = it.pulses[i];
        rpm = (diff * 60000) / den;
      end
      if (fwd_now[i] != fwd_goal[i] && rpm == 0) fwd_now[i] = fwd_goal[i];
      step = max_err != 0 ? (slew * err[i]) / max_err : 0;
      if (fwd_now[i] != fwd_goal[i]) begin
        pwm_now[i] = pwm_now[i] > step ? pwm_now[i] - step : 0;
      end else if (pwm_now[i] < pwm_goal[i]) begin
        pwm_now[i] += step;
        if (pwm_now[i] > pwm_goal[i]) pwm_now[i] = pwm_goal[i];
      end else if (pwm_now[i] > pwm_goal[i]) begin
        pwm_now[i] = pwm_now[i] - pwm_goal[i] > step ? pwm_now[i] - step : pwm_goal[i];
      end
      if (rpm > 32767) rpm = 32767;
      if (rpm < -32768) rpm = -32768;
      rep.speed[i] = 16'(rpm);
    end
    // Command timer saturates at 32 bits.
    quiet_ms = (quiet_ms > 32'hFFFF_FFFF - it.elapsed) ? 32'hFFFF_FFFF : quiet_ms + it.elapsed;
    if (quiet_ms > timeout_ms) begin
      for (int i = 0; i < 4; i++) begin
        pwm_goal[i] = 0;
        fwd_goal[i] = 1'b1;
      end
    end
    for (int i = 0; i < 4; i++) begin
      s = longint'(pwm_now[i]);
      rep.drive[i] = 13'(fwd_now[i] ? s : -s);
    end
    return 1'b1;
  endfunction

  // Register write through the configuration channel.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    #1;
    while (!cfg_ch.ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    case (idx)
      CFG_HALF_TRACK: track_half = value;
      CFG_VEL_GAIN:   gain = value;
      CFG_PWM_MAX:    pwm_cap = value[11:0];
      CFG_RAMP_STEP:  slew = value[7:0];
      CFG_TIMEOUT:    timeout_ms = value;
      default: ;
    endcase
  endtask

  // Send one item, holding valid over back-to-back transfers.
  task automatic send_item(drive_item_t it);
    int unsigned gap;
    motor_report_t rep;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd = it.tick;
    in_ch.linear_vel = it.lin;
    in_ch.angular_vel = it.ang;
    in_ch.elapsed_ms = it.elapsed;
    in_ch.pulses_fl = it.pulses[0];
    in_ch.pulses_fr = it.pulses[1];
    in_ch.pulses_rl = it.pulses[2];
    in_ch.pulses_rr = it.pulses[3];
    in_ch.valid = 1'b1;
    #1;
    while (!in_ch.ready) begin
      @(negedge clk);
      #1;
    end
    // The transfer happens at the coming rising edge.
    if (predict_motion(it, rep)) begin
      report_queue.push_back(it.typed ? it.typed_report : rep);
      ticks_sent++;
    end else begin
      cmds_sent++;
    end
    @(negedge clk);
  endtask

  // Result side: random stalls, checks at each transfer.
  initial begin : result_side
    int unsigned hold;
    motor_report_t want, got;
    bit bad;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else begin
        out_ch.ready = rst_n;
        if ($urandom_range(0, 99) < 15) hold = pick_gap();
      end
      #1;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.drive[0] = out_ch.drive_fl;
        got.drive[1] = out_ch.drive_fr;
        got.drive[2] = out_ch.drive_rl;
        got.drive[3] = out_ch.drive_rr;
        got.speed[0] = out_ch.speed_fl;
        got.speed[1] = out_ch.speed_fr;
        got.speed[2] = out_ch.speed_rl;
        got.speed[3] = out_ch.speed_rr;
        if (report_queue.size() == 0) begin
          errors++;
          $display("Result transfer with no report awaited at cycle %0d", cycles);
        end else begin
          want = report_queue.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 4; i++)
            if (got.drive[i] !== want.drive[i] || got.speed[i] !== want.speed[i]) bad = 1'b1;
          if (bad) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at cycle %0d: drive %0d %0d %0d %0d speed %0d %0d %0d %0d,%s",
                       cycles, got.drive[0], got.drive[1], got.drive[2], got.drive[3],
                       got.speed[0], got.speed[1], got.speed[2], got.speed[3],
                       $sformatf(" expected drive %0d %0d %0d %0d speed %0d %0d %0d %0d",
                                 want.drive[0], want.drive[1], want.drive[2], want.drive[3],
                                 want.speed[0], want.speed[1], want.speed[2], want.speed[3]));
          end
        end
      end
    end
  end

  // Directed row with optional typed report.
  task automatic add_row(bit tick, int lin, int ang, int el, logic [31:0] p0, logic [31:0] p1,
                         logic [31:0] p2, logic [31:0] p3, bit typed, int d, int s0, int s1,
                         int s2, int s3);
    drive_item_t r;
    r.tick = tick;
    r.lin = 16'(lin);
    r.ang = 16'(ang);
    r.elapsed = 16'(el);
    r.pulses[0] = p0;
    r.pulses[1] = p1;
    r.pulses[2] = p2;
    r.pulses[3] = p3;
    r.typed = typed;
    for (int i = 0; i < 4; i++) r.typed_report.drive[i] = 13'(d);
    r.typed_report.speed[0] = 16'(s0);
    r.typed_report.speed[1] = 16'(s1);
    r.typed_report.speed[2] = 16'(s2);
    r.typed_report.speed[3] = 16'(s3);
    directed_rows.push_back(r);
  endtask

  // Wait for all reports, then for the block to settle before a write.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (report_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random item: mostly regular ticks and commands, some noise.
  task automatic random_item();
    drive_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.typed = 1'b0;
    it.lin = $urandom;
    it.ang = $urandom;
    it.elapsed = $urandom;
    for (int i = 0; i < 4; i++) it.pulses[i] = $urandom;
    if (r < 14) begin
      it.tick = 1'b0;
      if ($urandom_range(0, 99) < 70) begin
        it.lin = 16'($signed($urandom_range(0, 1024)) - 512);
        it.ang = 16'($signed($urandom_range(0, 1024)) - 512);
      end
    end else begin
      it.tick = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 75) it.elapsed = $urandom_range(50, 150);
      else if (r < 85) it.elapsed = 0;
      else if (r < 90) it.elapsed = $urandom_range(1, 5);
      for (int i = 0; i < 4; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) it.pulses[i] = enc_pos[i];
        else if (r < 90) it.pulses[i] = enc_pos[i] + 32'($signed($urandom_range(0, 600)) - 300);
        if (it.elapsed != 0) enc_pos[i] = it.pulses[i];
      end
    end
    send_item(it);
  endtask

  initial begin : stimulus
    logic [15:0] cfg_set[5];
    cycles = 0;
    errors = 0;
    mismatches = 0;
    ticks_sent = 0;
    cmds_sent = 0;
    phases_run = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_HALF_TRACK;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.linear_vel = '0;
    in_ch.angular_vel = '0;
    in_ch.elapsed_ms = '0;
    in_ch.pulses_fl = '0;
    in_ch.pulses_fr = '0;
    in_ch.pulses_rl = '0;
    in_ch.pulses_rr = '0;
    reset_model();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at reset settings.
    // Zero elapsed time right after reset reports all zeros.
    add_row(1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // Encoder extremes saturate the speed; one pulse in one ms is 666 RPM.
    add_row(1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1, 0, 32767, -32768, 0, 666);
    add_row(1, 0, 0, 0, 5, 5, 5, 5, 0, 0, 0, 0, 0, 0);
    add_row(0, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 4; k++)
      add_row(1, 0, 0, 100, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0, 0, 0, 0, 0, 0);
    // Reversal held off while the wheels still turn.
    add_row(0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 100, 32'h7FFF_FFFF, 32'h8000_0100, 100, 200, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 100, 32'h7FFF_FFFF, 32'h8000_0100, 100, 200, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 100, 32'h7FFF_FFFF, 32'h8000_0100, 100, 200, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 100, 32'h7FFF_FF00, 32'h8000_0100, 100, 200, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 65535, 32'h0, 32'hFFFF_FFFF, 32'h8000_0064, 32'h7FFF_FFFF,
            0, 0, 0, 0, 0, 0);
    add_row(0, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 100, 32'h0, 32'hFFFF_FFFF, 32'h8000_0064, 32'h7FFF_FFFF,
            0, 0, 0, 0, 0, 0);
    // Long silence runs the command timer out.
    add_row(1, 0, 0, 65535, 32'h0, 32'hFFFF_FFFF, 32'h8000_0064, 32'h7FFF_FFFF,
            0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 100, 32'h0, 32'hFFFF_FFFF, 32'h8000_0064, 32'h7FFF_FFFF,
            0, 0, 0, 0, 0, 0);
    foreach (directed_rows[k]) send_item(directed_rows[k]);
    drain();

    // Phases of random traffic, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cfg_set = '{16'd2048, 16'd65280, 16'd255, 16'd3, 16'd5000};
        1: cfg_set = '{16'hFFFF, 16'hFFFF, 16'd4095, 16'd255, 16'hFFFF};
        2: cfg_set = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0};
        3: cfg_set = '{16'd4096, 16'd20000, 16'd0, 16'd40, 16'd300};
        4: cfg_set = '{16'd1000, 16'hFFFF, 16'd1, 16'd255, 16'd1000};
        default: begin
          cfg_set[0] = $urandom;
          cfg_set[1] = $urandom;
          cfg_set[2] = $urandom_range(1, 4095);
          cfg_set[3] = $urandom_range(0, 255);
          cfg_set[4] = $urandom;
        end
      endcase
      write_reg(CFG_HALF_TRACK, cfg_set[0]);
      write_reg(CFG_VEL_GAIN, cfg_set[1]);
      write_reg(CFG_PWM_MAX, cfg_set[2]);
      write_reg(CFG_RAMP_STEP, cfg_set[3]);
      write_reg(CFG_TIMEOUT, cfg_set[4]);
      for (int i = 0; i < 4; i++) enc_pos[i] = enc_last[i];
      calm = (ph == 5);
      repeat (210) random_item();
      in_ch.valid = 1'b0;
      drain();
      phases_run++;
    end

    if (report_queue.size() != 0) begin
      errors++;
      $display("%0d reports never arrived", report_queue.size());
    end
    $display("Ran %0d control ticks and %0d velocity commands over %0d register settings,",
             ticks_sent, cmds_sent, phases_run + 1);
    $display("with %0d failures and %0d report mismatches in %0d cycles.", errors, mismatches,
             cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
